// File: src/matrix_vector_multiply_bias_assert.svh
// Assertion macros for the modules of the matrix-vector block; the top module includes them.
`ifndef MATRIX_VECTOR_MULTIPLY_BIAS_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_BIAS_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define MVMB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mvmb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MVMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mvmb assertion failed");

`else

`define MVMB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MVMB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/mvmb_pkg.sv
package mvmb_pkg;

   // Fixed lane count and field widths of the beats.
   localparam int LANES      = 8;
   localparam int LANE_W     = 3;
   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 48;
   localparam int BIAS_W     = 32;
   localparam int CHUNK_W    = 7;
   localparam int CHUNKS_W   = 8;
   localparam int ROW_W      = 10;
   localparam int ROWCNT_W   = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Limits on the register values.
   localparam logic [CHUNKS_W-1:0] CHUNK_LIMIT    = 8'd128;
   localparam int                  ROW_HARD_LIMIT = 1024;

   // Defaults of the top-level parameters.
   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 1024;

   // Result queue depth, a power of two.
   localparam int QUEUE_DEPTH = 8;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_ROW  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COL_CHUNKS  = 2'd0,
      CSR_ROW_COUNT   = 2'd1,
      CSR_BIAS_ENABLE = 2'd2
   } csr_index_type;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // Control that travels alongside a beat through the lane stages.
   typedef struct packed {
      logic                     row;
      logic                     last;
      logic signed [BIAS_W-1:0] bias;
   } ctl_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] y_value;
      logic [ROW_W-1:0]        row_index;
      logic                    last_row;
   } rsp_type;

endpackage

// File: src/mvmb_req_if.sv
interface mvmb_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  opcode;
   logic [mvmb_pkg::CHUNK_W-1:0]          chunk;
   logic signed [mvmb_pkg::ELEM_W-1:0]    elem_0;
   logic signed [mvmb_pkg::ELEM_W-1:0]    elem_1;
   logic signed [mvmb_pkg::ELEM_W-1:0]    elem_2;
   logic signed [mvmb_pkg::ELEM_W-1:0]    elem_3;
   logic signed [mvmb_pkg::ELEM_W-1:0]    elem_4;
   logic signed [mvmb_pkg::ELEM_W-1:0]    elem_5;
   logic signed [mvmb_pkg::ELEM_W-1:0]    elem_6;
   logic signed [mvmb_pkg::ELEM_W-1:0]    elem_7;
   logic signed [mvmb_pkg::BIAS_W-1:0]    row_bias;

   modport source (
      output valid, opcode, chunk, elem_0, elem_1, elem_2, elem_3,
             elem_4, elem_5, elem_6, elem_7, row_bias,
      input  ready
   );

   modport sink (
      input  valid, opcode, chunk, elem_0, elem_1, elem_2, elem_3,
             elem_4, elem_5, elem_6, elem_7, row_bias,
      output ready
   );
endinterface

// File: src/mvmb_rsp_if.sv
interface mvmb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mvmb_pkg::ACC_W-1:0] y_value;
   logic [mvmb_pkg::ROW_W-1:0]        row_index;
   logic                              last_row;

   modport source (
      output valid, y_value, row_index, last_row,
      input  ready
   );

   modport sink (
      input  valid, y_value, row_index, last_row,
      output ready
   );
endinterface

// File: src/mvmb_ram.sv
module mvmb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/mvmb_lane.sv
module mvmb_lane #(
   parameter int MAX_COLS = mvmb_pkg::DEF_MAX_COLS,
   parameter int LANE_ID  = 0
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic                          rd_en,
   input  logic [mvmb_pkg::CHUNK_W-1:0]  chunk,
   input  mvmb_pkg::elem_type            elem,
   output mvmb_pkg::prod_type            product
);

   localparam int CHUNK_SPAN = 2 ** mvmb_pkg::CHUNK_W;
   localparam int COL_DEPTH  = (MAX_COLS + mvmb_pkg::LANES - 1) / mvmb_pkg::LANES;
   localparam int BANK_DEPTH = (COL_DEPTH < CHUNK_SPAN) ? COL_DEPTH : CHUNK_SPAN;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int COL_W      = mvmb_pkg::CHUNK_W + mvmb_pkg::LANE_W;

   logic [COL_W-1:0]                 col;
   logic                             col_ok;
   logic [mvmb_pkg::ELEM_W-1:0]      x_raw;
   mvmb_pkg::elem_type               elem_s1_ff;
   logic                             ok_s1_ff;
   mvmb_pkg::prod_type               product_in;
   mvmb_pkg::prod_type               product_ff;

   // Column of this lane for the chunk of the incoming beat.
   assign col    = {chunk, mvmb_pkg::LANE_W'(LANE_ID)};
   assign col_ok = (int'(col) < MAX_COLS);

   // This lane's bank of the vector store, addressed by chunk.
   mvmb_ram #(
      .WIDTH (mvmb_pkg::ELEM_W),
      .DEPTH (BANK_DEPTH)
   ) u_bank (
      .clock   (clock),
      .wr_en   (wr_en && col_ok),
      .wr_addr (chunk[AW-1:0]),
      .wr_data (elem),
      .rd_en   (rd_en),
      .rd_addr (chunk[AW-1:0]),
      .rd_data (x_raw)
   );

   // Hold the matrix element while the vector element is read.
   always_ff @(posedge clock) begin
      elem_s1_ff <= elem;
      ok_s1_ff   <= col_ok;
   end

   // Columns beyond the store contribute nothing.
   always_comb begin
      if (ok_s1_ff) begin
         product_in = elem_s1_ff * signed'(x_raw);
      end else begin
         product_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: src/mvmb_merge.sv
module mvmb_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  mvmb_pkg::ctl_type             ctl,
   input  mvmb_pkg::prod_type            products [mvmb_pkg::LANES],
   input  logic [mvmb_pkg::ROWCNT_W-1:0] nrows_m1,
   output logic                          retire,
   output logic                          push,
   output mvmb_pkg::rsp_type             result
);

   localparam int ACC_W  = mvmb_pkg::ACC_W;
   localparam int PROD_W = mvmb_pkg::PROD_W;
   localparam int BIAS_W = mvmb_pkg::BIAS_W;

   logic [ACC_W-1:0]              sum_in;
   logic [ACC_W-1:0]              sum_s3_ff;
   logic                          valid_s3_ff;
   logic                          row_s3_ff;
   logic                          last_s3_ff;
   logic [ACC_W-1:0]              acc_ff;
   logic [ACC_W-1:0]              acc_in;
   logic [mvmb_pkg::ROW_W-1:0]    row_cnt_ff;
   logic [mvmb_pkg::ROW_W-1:0]    row_cnt_in;
   logic [ACC_W-1:0]              y_sum;
   logic                          active;
   logic                          final_row;

   // Sum of the lane products and the bias of the beat.
   always_comb begin
      sum_in = {{(ACC_W - BIAS_W){ctl.bias[BIAS_W-1]}}, ctl.bias};
      for (int i = 0; i < mvmb_pkg::LANES; i++) begin
         sum_in = sum_in + {{(ACC_W - PROD_W){products[i][PROD_W-1]}}, products[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s3_ff <= 1'b0;
      end else begin
         valid_s3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sum_s3_ff  <= sum_in;
      row_s3_ff  <= ctl.row;
      last_s3_ff <= ctl.last;
   end

   // Row accumulation and the result at the last chunk of a row.
   assign y_sum     = acc_ff + sum_s3_ff;
   assign active    = valid_s3_ff && row_s3_ff;
   assign push      = active && last_s3_ff;
   assign retire    = valid_s3_ff;
   assign final_row = ({1'b0, row_cnt_ff} >= nrows_m1);

   always_comb begin
      acc_in     = acc_ff;
      row_cnt_in = row_cnt_ff;
      if (active) begin
         if (last_s3_ff) begin
            acc_in = '0;
            if (final_row) begin
               row_cnt_in = '0;
            end else begin
               row_cnt_in = row_cnt_ff + 1'b1;
            end
         end else begin
            acc_in = y_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         row_cnt_ff <= '0;
      end else begin
         acc_ff     <= acc_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   assign result.y_value   = signed'(y_sum);
   assign result.row_index = row_cnt_ff;
   assign result.last_row  = final_row;

endmodule

// File: src/matrix_vector_multiply_bias.sv
// Matrix-vector multiply with bias, y = A*x + bias, one row at a time.
// The req channel takes beats of two kinds: a load beat writes eight elements
// of x into the vector store, and a row beat brings eight elements of one
// chunk of the current matrix row, plus the row bias used on its last chunk.
// The rsp channel gives one beat per finished row: the sum, the row index and
// a flag on the final row. The csr port sets the chunks per row, the row count
// and the bias enable; write it only while the block is idle.
// A beat is accepted every cycle while fewer than eight beats are pending. Its
// lanes read the vector store, multiply, and a merge stage adds the lanes into
// the row accumulator; a finished row's result is written into the queue for rsp.
// Results wait in an eight-entry queue. When the receiver stalls, the block
// keeps accepting beats until the queue and the stages hold eight beats.
// Reset clears the registers to one chunk, one row and no bias, and clears the
// accumulator and row index; the vector store is not cleared and must be
// loaded before use.
module matrix_vector_multiply_bias #(
   parameter int MAX_COLS = mvmb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = mvmb_pkg::DEF_MAX_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   mvmb_req_if.sink                        req_bus,
   mvmb_rsp_if.source                      rsp_bus,
   input  logic                            csr_write_en,
   input  logic [mvmb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mvmb_pkg::CSR_DATA_W-1:0] csr_wdata
);

`include "matrix_vector_multiply_bias_assert.svh"

   localparam int LANES     = mvmb_pkg::LANES;
   localparam int ROWCNT_W  = mvmb_pkg::ROWCNT_W;
   localparam int CHUNKS_W  = mvmb_pkg::CHUNKS_W;
   localparam int ROW_LIMIT = (MAX_ROWS < mvmb_pkg::ROW_HARD_LIMIT) ?
                              MAX_ROWS : mvmb_pkg::ROW_HARD_LIMIT;
   localparam int QD        = mvmb_pkg::QUEUE_DEPTH;
   localparam int QPTR_W    = $clog2(QD);
   localparam int QCNT_W    = $clog2(QD + 1);

   logic [CHUNKS_W-1:0]       col_chunks_ff;
   logic [CHUNKS_W-1:0]       col_chunks_in;
   logic [ROWCNT_W-1:0]       row_count_ff;
   logic [ROWCNT_W-1:0]       row_count_in;
   logic                      bias_enable_ff;
   logic                      bias_enable_in;

   logic [CHUNKS_W-1:0]       nch;
   logic [CHUNKS_W-1:0]       nch_m1;
   logic [ROWCNT_W-1:0]       nrows;
   logic [ROWCNT_W-1:0]       nrows_m1;

   logic                      req_fire;
   logic                      is_load;
   logic                      is_row;
   mvmb_pkg::ctl_type         ctl_s1_in;
   mvmb_pkg::ctl_type         ctl_s1_ff;
   mvmb_pkg::ctl_type         ctl_s2_ff;
   logic                      valid_s1_ff;
   logic                      valid_s2_ff;
   mvmb_pkg::elem_type        elems [LANES];
   mvmb_pkg::prod_type        products [LANES];

   logic                      retire;
   logic                      push;
   mvmb_pkg::rsp_type         push_data;
   logic                      pop;
   mvmb_pkg::rsp_type         q_mem_ff [QD];
   logic [QPTR_W-1:0]         q_wr_ptr_ff;
   logic [QPTR_W-1:0]         q_rd_ptr_ff;
   logic [QCNT_W-1:0]         q_count_ff;
   logic [QCNT_W-1:0]         q_count_in;
   logic [QCNT_W-1:0]         pending_ff;
   logic [QCNT_W-1:0]         pending_in;
   mvmb_pkg::rsp_type         q_head;

   // Configuration registers.
   always_comb begin
      col_chunks_in  = col_chunks_ff;
      row_count_in   = row_count_ff;
      bias_enable_in = bias_enable_ff;
      if (csr_write_en) begin
         case (csr_index)
            mvmb_pkg::CSR_COL_CHUNKS:  col_chunks_in  = csr_wdata[CHUNKS_W-1:0];
            mvmb_pkg::CSR_ROW_COUNT:   row_count_in   = csr_wdata[ROWCNT_W-1:0];
            mvmb_pkg::CSR_BIAS_ENABLE: bias_enable_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_chunks_ff  <= CHUNKS_W'(1);
         row_count_ff   <= ROWCNT_W'(1);
         bias_enable_ff <= 1'b0;
      end else begin
         col_chunks_ff  <= col_chunks_in;
         row_count_ff   <= row_count_in;
         bias_enable_ff <= bias_enable_in;
      end
   end

   // Register values clamped to their working ranges.
   always_comb begin
      if (col_chunks_ff == '0) begin
         nch = CHUNKS_W'(1);
      end else if (col_chunks_ff > mvmb_pkg::CHUNK_LIMIT) begin
         nch = mvmb_pkg::CHUNK_LIMIT;
      end else begin
         nch = col_chunks_ff;
      end
      if (row_count_ff == '0) begin
         nrows = ROWCNT_W'(1);
      end else if (row_count_ff > ROWCNT_W'(ROW_LIMIT)) begin
         nrows = ROWCNT_W'(ROW_LIMIT);
      end else begin
         nrows = row_count_ff;
      end
   end

   assign nch_m1   = nch - 1'b1;
   assign nrows_m1 = nrows - 1'b1;

   // Beat acceptance and decoding.
   assign req_bus.ready = (pending_ff < QCNT_W'(QD));
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign is_load       = req_fire && (req_bus.opcode == mvmb_pkg::OP_LOAD);
   assign is_row        = req_fire && (req_bus.opcode == mvmb_pkg::OP_ROW);

   always_comb begin
      ctl_s1_in.row  = is_row && ({1'b0, req_bus.chunk} < nch);
      ctl_s1_in.last = ({1'b0, req_bus.chunk} == nch_m1);
      if (bias_enable_ff && ctl_s1_in.last) begin
         ctl_s1_in.bias = req_bus.row_bias;
      end else begin
         ctl_s1_in.bias = '0;
      end
   end

   assign elems[0] = req_bus.elem_0;
   assign elems[1] = req_bus.elem_1;
   assign elems[2] = req_bus.elem_2;
   assign elems[3] = req_bus.elem_3;
   assign elems[4] = req_bus.elem_4;
   assign elems[5] = req_bus.elem_5;
   assign elems[6] = req_bus.elem_6;
   assign elems[7] = req_bus.elem_7;

   // Control stages matching the store read and the multiply.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
      end else begin
         valid_s1_ff <= req_fire;
         valid_s2_ff <= valid_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ctl_s1_ff <= ctl_s1_in;
      ctl_s2_ff <= ctl_s1_ff;
   end

   // Multiply lanes, each with its own bank of the vector store.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      mvmb_lane #(
         .MAX_COLS (MAX_COLS),
         .LANE_ID  (g)
      ) u_lane (
         .clock   (clock),
         .wr_en   (is_load),
         .rd_en   (is_row),
         .chunk   (req_bus.chunk),
         .elem    (elems[g]),
         .product (products[g])
      );
   end

   // Lane sum and row accumulation.
   mvmb_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_s2_ff),
      .ctl      (ctl_s2_ff),
      .products (products),
      .nrows_m1 (nrows_m1),
      .retire   (retire),
      .push     (push),
      .result   (push_data)
   );

   // Result queue.
   assign pop = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[q_wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      q_count_in = q_count_ff;
      if (push && !pop) begin
         q_count_in = q_count_ff + 1'b1;
      end else if (pop && !push) begin
         q_count_in = q_count_ff - 1'b1;
      end
   end

   // Beats in the stages plus results in the queue; this bounds acceptance.
   always_comb begin
      pending_in = pending_ff;
      if (req_fire) begin
         pending_in = pending_in + 1'b1;
      end
      if (retire && !push) begin
         pending_in = pending_in - 1'b1;
      end
      if (pop) begin
         pending_in = pending_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
         pending_ff  <= '0;
      end else begin
         q_count_ff <= q_count_in;
         pending_ff <= pending_in;
         if (push) begin
            q_wr_ptr_ff <= q_wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            q_rd_ptr_ff <= q_rd_ptr_ff + 1'b1;
         end
      end
   end

   assign q_head            = q_mem_ff[q_rd_ptr_ff];
   assign rsp_bus.valid     = (q_count_ff != '0);
   assign rsp_bus.y_value   = q_head.y_value;
   assign rsp_bus.row_index = q_head.row_index;
   assign rsp_bus.last_row  = q_head.last_row;

   // The acceptance bound covers every queued result.
   `MVMB_ASSERT_IMPLY(a_pending_bound, clock, reset, 1'b1, pending_ff <= QCNT_W'(QD))
   `MVMB_ASSERT_IMPLY(a_queue_in_pending, clock, reset, 1'b1, q_count_ff <= pending_ff)
   `MVMB_ASSERT_IMPLY(a_no_push_when_full, clock, reset, push, q_count_ff < QCNT_W'(QD))
   `MVMB_ASSERT_NEXT(a_retire_follows_fire, clock, reset, req_fire, ##2 retire)

endmodule
